// File: hw/rtl/ibr_pkg.sv
// ----------------------------------------------------------------------------
// ibr_pkg: shared types and constants for the iBUS receiver
// Register indexes, item codes, sequencer states and channel reset values.
// ----------------------------------------------------------------------------
package ibr_pkg;

	// Channel store is always fourteen entries wide
	localparam int STORE_CH = 14;
	localparam int CH_W     = 4;
	localparam int AUX_CH   = 4;
	localparam int THR_CH   = 2;

	// Reset values
	localparam logic [15:0] GAP_LIMIT_RST     = 16'd3000;
	localparam logic [23:0] FRAME_TIMEOUT_RST = 24'd100000;
	localparam logic [15:0] ARM_THR_RST       = 16'd1700;
	localparam logic [15:0] DISARM_THR_RST    = 16'd1300;
	localparam logic [15:0] THROTTLE_LIM_RST  = 16'd1050;
	localparam logic [7:0]  HEADER_FIRST_RST  = 8'h20;
	localparam logic [7:0]  HEADER_SECOND_RST = 8'h40;
	localparam logic [15:0] SUM_INIT          = 16'hFFFF;
	localparam logic [15:0] CH_RESET_MID      = 16'd1500;
	localparam logic [15:0] CH_RESET_LOW      = 16'd1000;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_GAP_LIMIT     = 3'd0,
		REG_FRAME_TIMEOUT = 3'd1,
		REG_ARM_THR       = 3'd2,
		REG_DISARM_THR    = 3'd3,
		REG_THROTTLE_LIM  = 3'd4,
		REG_HEADER_FIRST  = 3'd5,
		REG_HEADER_SECOND = 3'd6
	} reg_idx_t;

	// Input item and result codes
	localparam logic OP_BYTE      = 1'b0;
	localparam logic OP_TICK      = 1'b1;
	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic [15:0] gap_limit;
		logic [23:0] frame_timeout;
		logic [15:0] arm_threshold;
		logic [15:0] disarm_threshold;
		logic [15:0] throttle_limit;
		logic [7:0]  header_first;
		logic [7:0]  header_second;
	} cfg_t;

	// Operand pairs of the shared comparator
	typedef enum logic [2:0] {
		CMP_GAP,
		CMP_FRAME,
		CMP_DISARM,
		CMP_ARM,
		CMP_THROTTLE
	} cmp_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LO,
		ST_RD_HI,
		ST_EMIT,
		ST_T_GAP,
		ST_T_FS,
		ST_T_DIS,
		ST_T_ARM,
		ST_T_THR,
		ST_T_STAT
	} state_t;

	function automatic logic [15:0] ch_reset(input int unsigned idx);
		logic [15:0] val;
		val = CH_RESET_LOW;
		if (idx == 0 || idx == 1 || idx == 3) begin
			val = CH_RESET_MID;
		end
		return val;
	endfunction

endpackage

// File: hw/rtl/ibr_in_if.sv
// ----------------------------------------------------------------------------
// ibr_in_if: input item channel
// Carries a received byte or a one microsecond tick with valid/ready.
// ----------------------------------------------------------------------------
interface ibr_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

// File: hw/rtl/ibr_out_if.sv
// ----------------------------------------------------------------------------
// ibr_out_if: result channel
// Carries channel value and status change results with valid/ready.
// ----------------------------------------------------------------------------
interface ibr_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  channel_index;
	logic [15:0] channel_value;
	logic        last;
	logic        failsafe;
	logic        armed;

	modport source (
		output valid, output kind, output channel_index, output channel_value,
		output last, output failsafe, output armed, input ready
	);
	modport sink (
		input valid, input kind, input channel_index, input channel_value,
		input last, input failsafe, input armed, output ready
	);
endinterface

// File: hw/rtl/ibr_ram.sv
// ----------------------------------------------------------------------------
// ibr_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ibr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/ibr_cmp.sv
// ----------------------------------------------------------------------------
// ibr_cmp: shared comparator
// Selects one operand pair of the tick evaluation and tests a < b unsigned.
// ----------------------------------------------------------------------------
module ibr_cmp (
	input  ibr_pkg::cfg_t     cfg,
	input  ibr_pkg::cmp_sel_t sel,
	input  logic [15:0]       gap_timer,
	input  logic [23:0]       frame_timer,
	input  logic [15:0]       aux,
	input  logic [15:0]       thr,
	output logic              lt
);
	import ibr_pkg::*;

	logic [23:0] op_a;
	logic [23:0] op_b;

	// Route the operand pair for this step
	always_comb begin
		unique case (sel)
			CMP_GAP: begin
				op_a = {8'd0, cfg.gap_limit};
				op_b = {8'd0, gap_timer};
			end
			CMP_FRAME: begin
				op_a = cfg.frame_timeout;
				op_b = frame_timer;
			end
			CMP_DISARM: begin
				op_a = {8'd0, aux};
				op_b = {8'd0, cfg.disarm_threshold};
			end
			CMP_ARM: begin
				op_a = {8'd0, cfg.arm_threshold};
				op_b = {8'd0, aux};
			end
			CMP_THROTTLE: begin
				op_a = {8'd0, thr};
				op_b = {8'd0, cfg.throttle_limit};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign lt = op_a < op_b;

endmodule

// File: hw/rtl/ibus_receiver_with_failsafe_arming_unit.sv
// ----------------------------------------------------------------------------
// ibus_receiver_with_failsafe_arming_unit: iBUS frame parser with failsafe
// Parses header-synced iBUS frames, reports channels, tracks arming state.
// ----------------------------------------------------------------------------
// Usage:
//   items carries either a received byte (opcode 0) or a 1 us tick
//   (opcode 1). results carries channel values (kind 0) and status changes
//   (kind 1). Configuration registers are written through cfg_we,
//   cfg_index and cfg_wdata; the user must write them only while the block
//   is idle, the block itself does not enforce this. A byte that does not
//   end a valid frame keeps the sequencer idle. The last byte of a valid
//   frame starts a run over N channels, two byte reads per channel through
//   the single read port of the frame RAM. A tick runs the timer update,
//   one test per step on the shared comparator, then the status check.
//   The block takes one item at a time; the last result of an item may
//   still wait in the output register while the next item is taken.
//   When the receiver stalls, the sequencer holds until the output register
//   frees up. Reset restores the register defaults, the channel defaults,
//   clears failsafe and armed and sets the boot guard; no clearing pass.
// ----------------------------------------------------------------------------
module ibus_receiver_with_failsafe_arming_unit #(
	parameter int CHANNEL_COUNT = 14,
	parameter int FRAME_BYTES   = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ibr_in_if.sink       items,
	ibr_out_if.source    results,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_wdata
);
	import ibr_pkg::*;

	localparam int IDX_W   = $clog2(FRAME_BYTES);
	localparam int NCH_RAW = (FRAME_BYTES - 4) / 2;
	localparam int NCH     = (NCH_RAW < CHANNEL_COUNT) ? NCH_RAW : CHANNEL_COUNT;

	cfg_t             cfg_q;
	state_t           state_q, state_d;
	logic [IDX_W-1:0] byte_idx_q;
	logic [15:0]      sum_q;
	logic [7:0]       lo_q;
	logic [15:0]      gap_q;
	logic [23:0]      frame_q;
	logic [15:0]      store_q [0:STORE_CH-1];
	logic             fs_q, armed_q, guard_q;
	logic             fs0_q, ar0_q;
	logic             aux_low_q, aux_high_q;
	logic [CH_W-1:0]  ch_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [3:0]       out_index_q;
	logic [15:0]      out_value_q;
	logic             out_last_q;
	logic             out_fs_q;
	logic             out_armed_q;

	logic             in_ready;
	logic             accept;
	logic             acc_byte, acc_tick;
	logic             hdr_skip, hdr_bad, take, last_byte, frame_ok, sum_byte;
	logic             out_free;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;
	logic [5:0]       lo_addr, hi_addr;
	cmp_sel_t         cmp_sel;
	logic             cmp_lt;
	logic             ch_last;
	logic             stat_diff;
	logic             load_ch, load_st;
	logic [15:0]      ch_value;

	// Handshake and byte classification
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = items.valid && in_ready;
	assign acc_byte  = accept && (items.opcode == OP_BYTE);
	assign acc_tick  = accept && (items.opcode == OP_TICK);
	assign hdr_skip  = (byte_idx_q == '0) && (items.rx_byte != cfg_q.header_first);
	assign hdr_bad   = (byte_idx_q == IDX_W'(1)) && (items.rx_byte != cfg_q.header_second);
	assign take      = !hdr_skip && !hdr_bad;
	assign last_byte = (byte_idx_q == IDX_W'(FRAME_BYTES - 1));
	assign sum_byte  = (byte_idx_q < IDX_W'(FRAME_BYTES - 2));
	assign frame_ok  = ({items.rx_byte, lo_q} == sum_q);

	assign out_free  = !out_valid_q || results.ready;
	assign lo_addr   = {1'b0, ch_q, 1'b0} + 6'd2;
	assign hi_addr   = {1'b0, ch_q, 1'b0} + 6'd3;
	assign ch_last   = (ch_q == CH_W'(NCH - 1));
	assign stat_diff = (fs_q != fs0_q) || (armed_q != ar0_q);
	assign ch_value  = {ram_rdata, lo_q};
	assign load_ch   = (state_q == ST_EMIT) && out_free;
	assign load_st   = (state_q == ST_T_STAT) && stat_diff && out_free;

	// Frame buffer
	ibr_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (acc_byte && take),
		.waddr (byte_idx_q),
		.wdata (items.rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared comparator for tick evaluation
	ibr_cmp u_cmp (
		.cfg         (cfg_q),
		.sel         (cmp_sel),
		.gap_timer   (gap_q),
		.frame_timer (frame_q),
		.aux         (store_q[AUX_CH]),
		.thr         (store_q[THR_CH]),
		.lt          (cmp_lt)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_byte && take && last_byte && frame_ok) begin
					state_d = ST_RD_LO;
				end else if (acc_tick) begin
					state_d = ST_T_GAP;
				end
			end
			ST_RD_LO:  state_d = ST_RD_HI;
			ST_RD_HI:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ch_last ? ST_IDLE : ST_RD_LO;
				end
			end
			ST_T_GAP:  state_d = ST_T_FS;
			ST_T_FS:   state_d = ST_T_DIS;
			ST_T_DIS:  state_d = ST_T_ARM;
			ST_T_ARM:  state_d = ST_T_THR;
			ST_T_THR:  state_d = ST_T_STAT;
			ST_T_STAT: begin
				if (!stat_diff || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = IDX_W'(lo_addr);
		cmp_sel   = CMP_GAP;
		unique case (state_q)
			ST_RD_LO: begin
				ram_re    = 1'b1;
				ram_raddr = IDX_W'(lo_addr);
			end
			ST_RD_HI: begin
				ram_re    = 1'b1;
				ram_raddr = IDX_W'(hi_addr);
			end
			ST_T_GAP:  cmp_sel = CMP_GAP;
			ST_T_FS:   cmp_sel = CMP_FRAME;
			ST_T_DIS:  cmp_sel = CMP_DISARM;
			ST_T_ARM:  cmp_sel = CMP_ARM;
			ST_T_THR:  cmp_sel = CMP_THROTTLE;
			default: begin
				ram_re  = 1'b0;
				cmp_sel = CMP_GAP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit        <= GAP_LIMIT_RST;
			cfg_q.frame_timeout    <= FRAME_TIMEOUT_RST;
			cfg_q.arm_threshold    <= ARM_THR_RST;
			cfg_q.disarm_threshold <= DISARM_THR_RST;
			cfg_q.throttle_limit   <= THROTTLE_LIM_RST;
			cfg_q.header_first     <= HEADER_FIRST_RST;
			cfg_q.header_second    <= HEADER_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAP_LIMIT:     cfg_q.gap_limit        <= cfg_wdata[15:0];
				REG_FRAME_TIMEOUT: cfg_q.frame_timeout    <= cfg_wdata;
				REG_ARM_THR:       cfg_q.arm_threshold    <= cfg_wdata[15:0];
				REG_DISARM_THR:    cfg_q.disarm_threshold <= cfg_wdata[15:0];
				REG_THROTTLE_LIM:  cfg_q.throttle_limit   <= cfg_wdata[15:0];
				REG_HEADER_FIRST:  cfg_q.header_first     <= cfg_wdata[7:0];
				REG_HEADER_SECOND: cfg_q.header_second    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Frame parser, timers and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			sum_q      <= SUM_INIT;
			gap_q      <= '0;
			frame_q    <= '0;
			fs_q       <= 1'b0;
			armed_q    <= 1'b0;
			guard_q    <= 1'b1;
			fs0_q      <= 1'b0;
			ar0_q      <= 1'b0;
			aux_low_q  <= 1'b0;
			aux_high_q <= 1'b0;
			ch_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_byte) begin
						gap_q <= '0;
						ch_q  <= '0;
						if (hdr_bad) begin
							byte_idx_q <= '0;
							sum_q      <= SUM_INIT;
						end else if (take) begin
							if (sum_byte) begin
								sum_q <= sum_q - {8'd0, items.rx_byte};
							end
							if (last_byte) begin
								byte_idx_q <= '0;
								sum_q      <= SUM_INIT;
								if (frame_ok) begin
									frame_q <= '0;
								end
							end else begin
								byte_idx_q <= byte_idx_q + IDX_W'(1);
							end
						end
					end else if (acc_tick) begin
						// Saturating timer advance, remember flags for the status check
						fs0_q <= fs_q;
						ar0_q <= armed_q;
						if (gap_q != '1) begin
							gap_q <= gap_q + 16'd1;
						end
						if (frame_q != '1) begin
							frame_q <= frame_q + 24'd1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ch_q <= ch_q + CH_W'(1);
					end
				end
				ST_T_GAP: begin
					if ((byte_idx_q != '0) && cmp_lt) begin
						byte_idx_q <= '0;
						sum_q      <= SUM_INIT;
					end
				end
				ST_T_FS: begin
					fs_q <= cmp_lt;
					if (cmp_lt) begin
						armed_q <= 1'b0;
					end
				end
				ST_T_DIS: begin
					aux_low_q <= cmp_lt;
					if (cmp_lt) begin
						guard_q <= 1'b0;
					end
				end
				ST_T_ARM: begin
					aux_high_q <= cmp_lt;
				end
				ST_T_THR: begin
					if (!fs_q && !armed_q && !guard_q && aux_high_q && cmp_lt) begin
						armed_q <= 1'b1;
					end else if (aux_low_q || fs_q) begin
						armed_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Checksum low byte, reused as the channel low byte during a run
	always_ff @(posedge clk) begin
		if (acc_byte && take && (byte_idx_q == IDX_W'(FRAME_BYTES - 2))) begin
			lo_q <= items.rx_byte;
		end else if (state_q == ST_RD_HI) begin
			lo_q <= ram_rdata;
		end
	end

	// Channel store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_CH; i++) begin
				store_q[i] <= ch_reset(i);
			end
		end else if (load_ch) begin
			store_q[ch_q] <= ch_value;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_ch || load_st) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ch) begin
			out_kind_q  <= KIND_CHANNEL;
			out_index_q <= ch_q;
			out_value_q <= ch_value;
			out_last_q  <= ch_last;
			out_fs_q    <= fs_q;
			out_armed_q <= armed_q;
		end else if (load_st) begin
			out_kind_q  <= KIND_STATUS;
			out_index_q <= '0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
			out_fs_q    <= fs_q;
			out_armed_q <= armed_q;
		end
	end

	assign items.ready           = in_ready;
	assign results.valid         = out_valid_q;
	assign results.kind          = out_kind_q;
	assign results.channel_index = out_index_q;
	assign results.channel_value = out_value_q;
	assign results.last          = out_last_q;
	assign results.failsafe      = out_fs_q;
	assign results.armed         = out_armed_q;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the iBUS receiver with failsafe arming
// Drives received bytes and microsecond ticks over the item channel and
// predicts every channel report and status change in a scoreboard class.
// Register settings move through defaults, both extremes and random values,
// with random idle bursts on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import ibr_pkg::*;

	localparam int CHANNELS      = 14;
	localparam int FRAME_LEN     = 32;
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD     = 400;
	localparam int LIMIT_CYCLES  = 1000000;
	// Index past the register list: the block must ignore the write
	localparam logic [2:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic        kind;
		logic [3:0]  index;
		logic [15:0] value;
		logic        last;
		logic        failsafe;
		logic        armed;
	} report_t;

	typedef logic [15:0] chan_set_t [CHANNELS];

	// Tracks parser, timer and arming state; holds the reports still due
	class ibus_tracker;
		cfg_t        regs;
		logic [7:0]  frame_buf [FRAME_LEN];
		int unsigned fill;
		logic [15:0] sum;
		logic [15:0] gap_ticks;
		logic [23:0] frame_ticks;
		logic [15:0] chan [CHANNELS];
		bit          failsafe;
		bit          armed;
		bit          boot_guard;
		report_t     due_reports [$];
		int          errors;
		int          checked;
		int          frames_ok;
		int          frames_bad;
		int          drops;
		int          status_changes;

		function new();
			regs = '{GAP_LIMIT_RST, FRAME_TIMEOUT_RST, ARM_THR_RST, DISARM_THR_RST,
				THROTTLE_LIM_RST, HEADER_FIRST_RST, HEADER_SECOND_RST};
			fill = 0;
			sum = SUM_INIT;
			gap_ticks = '0;
			frame_ticks = '0;
			for (int i = 0; i < CHANNELS; i++) begin
				chan[i] = (i == 0 || i == 1 || i == 3) ? CH_RESET_MID : CH_RESET_LOW;
			end
			failsafe = 0;
			armed = 0;
			boot_guard = 1;
		endfunction

		function void set_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				REG_GAP_LIMIT:     regs.gap_limit = val[15:0];
				REG_FRAME_TIMEOUT: regs.frame_timeout = val;
				REG_ARM_THR:       regs.arm_threshold = val[15:0];
				REG_DISARM_THR:    regs.disarm_threshold = val[15:0];
				REG_THROTTLE_LIM:  regs.throttle_limit = val[15:0];
				REG_HEADER_FIRST:  regs.header_first = val[7:0];
				REG_HEADER_SECOND: regs.header_second = val[7:0];
				default: ;
			endcase
		endfunction

		// Advance the state by one accepted item and queue the reports it causes
		function void take_item(logic op, logic [7:0] b);
			logic [15:0] aux;
			logic [15:0] thr;
			logic [15:0] got;
			bit          fs0;
			bit          ar0;
			if (op == OP_BYTE) begin
				gap_ticks = '0;
				if (fill == 0 && b != regs.header_first) return;
				if (fill == 1 && b != regs.header_second) begin
					fill = 0;
					sum = SUM_INIT;
					return;
				end
				frame_buf[fill] = b;
				if (fill < FRAME_LEN - 2) sum = sum - 16'(b);
				fill++;
				if (fill < FRAME_LEN) return;
				// Full frame: restart the parser whatever the checksum says
				fill = 0;
				got = {frame_buf[FRAME_LEN - 1], frame_buf[FRAME_LEN - 2]};
				if (got != sum) begin
					sum = SUM_INIT;
					frames_bad++;
					return;
				end
				sum = SUM_INIT;
				for (int ch = 0; ch < CHANNELS; ch++) begin
					chan[ch] = {frame_buf[3 + 2 * ch], frame_buf[2 + 2 * ch]};
				end
				frame_ticks = '0;
				for (int ch = 0; ch < CHANNELS; ch++) begin
					due_reports.push_back('{KIND_CHANNEL, 4'(ch), chan[ch],
						ch == CHANNELS - 1, failsafe, armed});
				end
				frames_ok++;
			end else begin
				fs0 = failsafe;
				ar0 = armed;
				aux = chan[AUX_CH];
				thr = chan[THR_CH];
				if (gap_ticks != 16'hFFFF) gap_ticks++;
				if (frame_ticks != 24'hFFFFFF) frame_ticks++;
				// Drop a stalled partial frame
				if (fill > 0 && gap_ticks > regs.gap_limit) begin
					fill = 0;
					sum = SUM_INIT;
					drops++;
				end
				if (frame_ticks > regs.frame_timeout) begin
					failsafe = 1;
					armed = 0;
				end else begin
					failsafe = 0;
				end
				if (aux < regs.disarm_threshold) boot_guard = 0;
				if (!failsafe && !armed && !boot_guard && aux > regs.arm_threshold &&
						thr < regs.throttle_limit) begin
					armed = 1;
				end else if (aux < regs.disarm_threshold || failsafe) begin
					armed = 0;
				end
				if (fs0 != failsafe || ar0 != armed) begin
					due_reports.push_back('{KIND_STATUS, 4'd0, 16'd0, 1'b0, failsafe, armed});
					status_changes++;
				end
			end
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: mismatch in %s: expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (due_reports.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: kind %0d index %0d value %0h",
					$time, got.kind, got.index, got.value);
				return;
			end
			want = due_reports.pop_front();
			checked++;
			compare_field("kind", 16'(want.kind), 16'(got.kind));
			compare_field("channel_index", 16'(want.index), 16'(got.index));
			compare_field("channel_value", want.value, got.value);
			compare_field("last", 16'(want.last), 16'(got.last));
			compare_field("failsafe", 16'(want.failsafe), 16'(got.failsafe));
			compare_field("armed", 16'(want.armed), 16'(got.armed));
		endfunction

		function int pending();
			return due_reports.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_wdata;

	ibr_in_if  items_if ();
	ibr_out_if results_if ();

	ibus_receiver_with_failsafe_arming_unit #(
		.CHANNEL_COUNT(CHANNELS),
		.FRAME_BYTES  (FRAME_LEN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items_if),
		.results  (results_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	ibus_tracker sb = new();
	int items_sent;
	int src_calm;
	int settings_applied;
	bit idle_on;
	bit long_hold_req;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Offer one item and hold it until the block takes the transfer
	task automatic send_item(input logic op, input logic [7:0] b);
		if (src_calm > 0) begin
			src_calm--;
		end else if (idle_on && $urandom_range(0, 1)) begin
			items_if.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end else begin
			src_calm = $urandom_range(5, 40);
		end
		items_if.valid <= 1'b1;
		items_if.opcode <= op;
		items_if.rx_byte <= b;
		do @(posedge clk); while (!items_if.ready);
		sb.take_item(op, b);
		items_sent++;
	endtask

	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++) send_item(OP_TICK, 8'($urandom));
	endtask

	// Send bytes [from, upto) of a frame built from the channel values
	task automatic send_frame(input chan_set_t v, input bit corrupt, input int from,
			input int upto);
		logic [7:0]  fb [FRAME_LEN];
		logic [15:0] csum;
		int          pick;
		fb[0] = sb.regs.header_first;
		fb[1] = sb.regs.header_second;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			fb[2 + 2 * ch] = v[ch][7:0];
			fb[3 + 2 * ch] = v[ch][15:8];
		end
		csum = SUM_INIT;
		for (int i = 0; i < FRAME_LEN - 2; i++) csum = csum - 16'(fb[i]);
		fb[FRAME_LEN - 2] = csum[7:0];
		fb[FRAME_LEN - 1] = csum[15:8];
		// One flipped bit past the header always breaks the checksum
		if (corrupt) begin
			pick = $urandom_range(2, FRAME_LEN - 1);
			fb[pick] = fb[pick] ^ 8'(1 << $urandom_range(0, 7));
		end
		for (int i = from; i < upto; i++) send_item(OP_BYTE, fb[i]);
	endtask

	// Mostly mid-range values; aux and throttle steered around the thresholds
	function automatic chan_set_t random_channels();
		chan_set_t v;
		int        r;
		int        arm;
		int        dis;
		int        lim;
		arm = int'(sb.regs.arm_threshold);
		dis = int'(sb.regs.disarm_threshold);
		lim = int'(sb.regs.throttle_limit);
		for (int ch = 0; ch < CHANNELS; ch++) begin
			r = $urandom_range(0, 9);
			if (r < 7) v[ch] = 16'($urandom_range(900, 2100));
			else if (r < 8) v[ch] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			else v[ch] = 16'($urandom);
		end
		r = $urandom_range(0, 2);
		if (r == 0 && dis > 0) v[AUX_CH] = 16'($urandom_range(0, dis - 1));
		else if (r == 1 && arm < 65535) v[AUX_CH] = 16'($urandom_range(arm + 1, 65535));
		if (lim > 0 && $urandom_range(0, 1)) v[THR_CH] = 16'($urandom_range(0, lim - 1));
		return v;
	endfunction

	// Drop valid, wait for every due report, then let the block settle
	task automatic wait_idle();
		items_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write every register, junk in the unused upper bits, then a stray index
	task automatic apply_settings(input cfg_t s);
		logic [23:0] junk;
		logic [23:0] data;
		for (int i = 0; i <= REG_NONE; i++) begin
			junk = 24'($urandom);
			case (3'(i))
				REG_GAP_LIMIT:     data = {junk[23:16], s.gap_limit};
				REG_FRAME_TIMEOUT: data = s.frame_timeout;
				REG_ARM_THR:       data = {junk[23:16], s.arm_threshold};
				REG_DISARM_THR:    data = {junk[23:16], s.disarm_threshold};
				REG_THROTTLE_LIM:  data = {junk[23:16], s.throttle_limit};
				REG_HEADER_FIRST:  data = {junk[23:8], s.header_first};
				REG_HEADER_SECOND: data = {junk[23:8], s.header_second};
				default:           data = junk;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= data;
			sb.set_reg(3'(i), data);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// Mix of good frames, tick bursts, noise and broken frames
	task automatic run_random(input int n_items);
		int        start;
		int        r;
		logic [7:0] b;
		start = items_sent;
		while (items_sent - start < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_frame(random_channels(), 1'b0, 0, FRAME_LEN);
			end else if (r < 65) begin
				send_ticks($urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : $urandom_range(1, 8));
			end else if (r < 72) begin
				repeat ($urandom_range(1, 4)) send_item(OP_BYTE, 8'($urandom));
			end else if (r < 80) begin
				send_frame(random_channels(), 1'b1, 0, FRAME_LEN);
			end else if (r < 90) begin
				send_frame(random_channels(), 1'b0, 0, $urandom_range(1, FRAME_LEN - 1));
				if (sb.regs.gap_limit < 64) send_ticks(sb.regs.gap_limit + $urandom_range(1, 3));
			end else begin
				b = 8'($urandom);
				if (b == sb.regs.header_second) b = ~b;
				send_item(OP_BYTE, sb.regs.header_first);
				send_item(OP_BYTE, b);
			end
		end
	endtask

	// Result sink: check each transfer, then pick ready for the next edge
	initial begin : result_sink
		int      stall_left;
		int      calm_left;
		int      hold_left;
		report_t got;
		bit      rdy;
		bit      hold_taken;
		stall_left = 0;
		calm_left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid && results_if.ready) begin
				got = '{results_if.kind, results_if.channel_index, results_if.channel_value,
					results_if.last, results_if.failsafe, results_if.armed};
				sb.check_report(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (long_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = LONG_HOLD - 1;
				rdy = 1'b0;
			end else if (!idle_on) begin
				rdy = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				rdy = 1'b1;
			end else if ($urandom_range(0, 1)) begin
				stall_left = $urandom_range(1, 18) - 1;
				rdy = 1'b0;
			end else begin
				calm_left = $urandom_range(4, 60);
				rdy = 1'b1;
			end
			results_if.ready <= rdy;
		end
	end

	// Watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles, %0d reports still due", $time, cycles,
			sb.pending());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		cfg_t      s;
		chan_set_t v;
		items_sent = 0;
		src_calm = 0;
		settings_applied = 0;
		idle_on = 1'b1;
		long_hold_req = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GAP_LIMIT;
		cfg_wdata <= '0;
		items_if.valid <= 1'b0;
		items_if.opcode <= OP_BYTE;
		items_if.rx_byte <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults: ignored tick byte, noise, header mismatch, arm and disarm
		send_item(OP_TICK, 8'hFF);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, HEADER_FIRST_RST);
		send_item(OP_BYTE, HEADER_FIRST_RST);
		v = random_channels();
		v[0] = 16'h0000;
		v[1] = 16'hFFFF;
		v[3] = 16'h8001;
		v[THR_CH] = 16'd1000;
		v[AUX_CH] = 16'd1000;
		send_frame(v, 1'b0, 0, FRAME_LEN);
		send_ticks(1);
		v[AUX_CH] = 16'd2000;
		send_frame(v, 1'b0, 0, FRAME_LEN);
		send_ticks(1);
		v[AUX_CH] = 16'd1000;
		send_frame(v, 1'b1, 0, FRAME_LEN);
		send_ticks(1);
		send_frame(v, 1'b0, 0, FRAME_LEN);
		send_ticks(1);
		wait_idle();

		// Short timers: gap at the limit keeps the frame, one more tick drops it
		s = '{16'd4, 24'd20, 16'd1700, 16'd1300, 16'd1050, 8'hA5, 8'h5A};
		apply_settings(s);
		v = random_channels();
		send_frame(v, 1'b0, 0, 10);
		send_ticks(4);
		send_frame(v, 1'b0, 10, FRAME_LEN);
		send_frame(v, 1'b0, 0, 10);
		send_ticks(5);
		send_frame(v, 1'b0, 0, FRAME_LEN);
		// Frame timeout raises failsafe; after a fresh frame the next tick clears it
		send_ticks(25);
		send_frame(random_channels(), 1'b0, 0, FRAME_LEN);
		send_ticks(1);
		// Hold off the receiver while frames keep coming
		long_hold_req = 1'b1;
		send_frame(random_channels(), 1'b0, 0, FRAME_LEN);
		run_random(15);
		wait_idle();

		// Low extremes
		s = '{16'd0, 24'd0, 16'hFFFF, 16'hFFFF, 16'd0, 8'h00, 8'hFF};
		apply_settings(s);
		run_random(15);
		wait_idle();

		// High extremes
		s = '{16'hFFFF, 24'hFFFFFF, 16'd0, 16'd0, 16'hFFFF, 8'hFF, 8'h00};
		apply_settings(s);
		run_random(15);
		wait_idle();

		// Random realistic settings, both sides at full rate
		s.gap_limit = 16'($urandom_range(0, 20));
		s.frame_timeout = 24'($urandom_range(5, 60));
		s.arm_threshold = 16'($urandom_range(1400, 1900));
		s.disarm_threshold = 16'($urandom_range(1000, 1500));
		s.throttle_limit = 16'($urandom_range(900, 1300));
		s.header_first = 8'($urandom);
		s.header_second = 8'($urandom);
		apply_settings(s);
		idle_on = 1'b0;
		run_random(15);
		wait_idle();

		$display("Sent %0d items over %0d register settings: %0d good frames, %0d bad frames",
			items_sent, settings_applied + 1, sb.frames_ok, sb.frames_bad);
		$display("Checked %0d results, %0d status changes, %0d partial frames dropped",
			sb.checked, sb.status_changes, sb.drops);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
